[rtl/spl_pkg.sv]
// ----------------------------------------------------------------------------
// spl_pkg: shared definitions of the cubic spline evaluator
// Widths, the knot record that travels around the ring and the status of
// the serial multiplier.
// ----------------------------------------------------------------------------
package spl_pkg;

   localparam int MAX_KNOTS = 64;
   localparam int KNOT_AW   = $clog2(MAX_KNOTS);

   localparam int CSR_W  = 7;
   localparam int IDX_W  = 6;
   localparam int POS_W  = 32;
   localparam int VAL_W  = 48;
   localparam int SLP_W  = 48;
   localparam int CRV_W  = 64;
   localparam int CUB_W  = 64;
   localparam int OUT_W  = 64;
   localparam int SEG_W  = 6;

   // dx is one bit wider than a position
   localparam int DX_W   = POS_W + 1;
   // multiplicand holds d, t or u; the widest (u) needs 85 bits
   localparam int MA_W   = 88;
   localparam int MB_W   = DX_W;
   localparam int PROD_W = MA_W + MB_W + 1;
   localparam int MCNT_W = $clog2(MB_W);
   // v before saturation
   localparam int V_W    = PROD_W - 16;

   localparam int REQ_DATA_W = 264;
   localparam int RSP_DATA_W = 72;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic signed [VAL_W-1:0] val;
      logic signed [SLP_W-1:0] slp;
      logic signed [CRV_W-1:0] crv;
      logic signed [CUB_W-1:0] cub;
   } knot_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

[rtl/cubic_spline_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// cubic_spline_evaluator_unit: piecewise cubic spline evaluator
// Knots live in a ring of cells that rotates by one every cycle; a serial
// multiplier runs the three Horner steps.
// ----------------------------------------------------------------------------
// One request at a time. A knot only becomes readable or writable when it
// passes the head of the ring, so each knot access waits for the ring to
// bring it round. An evaluate makes up to log2(MAX_KNOTS) + 3 knot accesses
// (two end checks, the search, the final fetch), then three passes of the
// serial multiplier, each a start, 33 bit steps (one per dx bit), done.
// A finished result waits in the output register while the next request
// is taken.
module cubic_spline_evaluator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // knot_index, x_point, coef_value, coef_slope, coef_curvature, coef_cubic
   input  logic [spl_pkg::REQ_DATA_W-1:0]      req_tdata,
   // op
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // spline_value, segment
   output logic [spl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // saturated
   output logic                                rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [spl_pkg::CSR_W-1:0]           csr_wr_data
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LOAD   = 9'b000000010,
      S_FIRST  = 9'b000000100,
      S_LAST   = 9'b000001000,
      S_SEARCH = 9'b000010000,
      S_FETCH  = 9'b000100000,
      S_MSTART = 9'b001000000,
      S_MWAIT  = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   localparam logic [1:0] STEP_T = 2'd0;
   localparam logic [1:0] STEP_U = 2'd1;
   localparam logic [1:0] STEP_V = 2'd2;

   localparam int AW = spl_pkg::KNOT_AW;

   state_type                          state_ff, state_in;
   logic [spl_pkg::CSR_W-1:0]          csr_ff;
   logic [AW-1:0]                      ptr_ff, ptr_in;
   logic [AW-1:0]                      tgt_ff, tgt_in;
   logic [AW-1:0]                      lo_ff, lo_in;
   logic [AW-1:0]                      hi_ff, hi_in;
   logic [1:0]                         step_ff, step_in;
   logic signed [spl_pkg::POS_W-1:0]   x_ff;
   spl_pkg::knot_type                  new_knot_ff;
   spl_pkg::knot_type                  cur_ff;
   logic signed [spl_pkg::DX_W-1:0]    dx_ff;
   logic signed [spl_pkg::MA_W-1:0]    acc_ff, acc_in;
   logic signed [spl_pkg::OUT_W-1:0]   res_val_ff, res_val_in;
   logic                               res_sat_ff, res_sat_in;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [spl_pkg::OUT_W-1:0]          rsp_val_ff;
   logic [spl_pkg::SEG_W-1:0]          rsp_seg_ff;
   logic                               rsp_sat_ff;
   logic                               rsp_load;

   spl_pkg::knot_type                  ring [spl_pkg::MAX_KNOTS];
   spl_pkg::knot_type                  head;
   logic                               hit;
   logic                               wr_en;
   logic                               capture;
   logic                               req_accept;
   logic [AW-1:0]                      last;
   logic [AW:0]                        mid_sum;
   logic [AW-1:0]                      nlo, nhi;

   logic                               mul_start;
   logic signed [spl_pkg::MA_W-1:0]    mult_a;
   spl_pkg::mul_stat_type              mul_stat;
   logic signed [spl_pkg::PROD_W-1:0]  product;
   logic signed [spl_pkg::PROD_W-1:0]  tmp20, tmp24, tmp16;
   logic signed [spl_pkg::V_W-1:0]     v_sum;
   logic                               v_ovf;

   // ---------------- knot ring ----------------
   for (genvar j = 0; j < spl_pkg::MAX_KNOTS; j++) begin : g_ring
      spl_cell u_cell (
         .clock     (clock),
         .shift_in  (ring[(j + 1) % spl_pkg::MAX_KNOTS]),
         .load_en   (wr_en && (j == spl_pkg::MAX_KNOTS - 1)),
         .load_knot (new_knot_ff),
         .knot_out  (ring[j])
      );
   end

   assign head = ring[0];
   assign hit  = (ptr_ff == tgt_ff);

   // ---------------- multiplier ----------------
   assign mult_a = (step_ff == STEP_T) ? spl_pkg::MA_W'(cur_ff.cub) : acc_ff;

   spl_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mult_a  (mult_a),
      .mult_b  (dx_ff),
      .stat    (mul_stat),
      .product (product)
   );

   // round half up before each rescale
   always_comb begin
      tmp20 = product + {{(spl_pkg::PROD_W - 20){1'b0}}, 1'b1, 19'b0};
      tmp24 = product + {{(spl_pkg::PROD_W - 24){1'b0}}, 1'b1, 23'b0};
      tmp16 = product + {{(spl_pkg::PROD_W - 16){1'b0}}, 1'b1, 15'b0};
      v_sum = spl_pkg::V_W'(tmp16 >>> 16) + spl_pkg::V_W'(cur_ff.val);
      v_ovf = (v_sum[spl_pkg::V_W-1:spl_pkg::OUT_W-1] !=
               {(spl_pkg::V_W - spl_pkg::OUT_W + 1){v_sum[spl_pkg::OUT_W-1]}});
   end

   // ---------------- control ----------------
   always_comb begin
      if (int'(csr_ff) < 2) begin
         last = AW'(1);
      end else if (int'(csr_ff) > spl_pkg::MAX_KNOTS) begin
         last = AW'(spl_pkg::MAX_KNOTS - 1);
      end else begin
         last = AW'(int'(csr_ff) - 1);
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);
   assign capture    = hit && ((state_ff == S_FIRST) || (state_ff == S_LAST) ||
                               (state_ff == S_SEARCH) || (state_ff == S_FETCH));

   always_comb begin
      state_in   = state_ff;
      tgt_in     = tgt_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      res_val_in = res_val_ff;
      res_sat_in = res_sat_ff;
      wr_en      = 1'b0;
      mul_start  = 1'b0;
      nlo        = lo_ff;
      nhi        = hi_ff;
      mid_sum    = '0;
      ptr_in     = (ptr_ff == AW'(spl_pkg::MAX_KNOTS - 1)) ? '0 : ptr_ff + 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               tgt_in  = AW'(req_tdata[spl_pkg::IDX_W-1:0]);
               step_in = STEP_T;
               if (req_tuser == spl_pkg::OP_EVAL) begin
                  tgt_in   = '0;
                  state_in = S_FIRST;
               end else if (int'(req_tdata[spl_pkg::IDX_W-1:0]) < spl_pkg::MAX_KNOTS) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            if (hit) begin
               wr_en    = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FIRST: begin
            if (hit) begin
               if (x_ff <= head.pos) begin
                  lo_in    = '0;
                  state_in = S_MSTART;
               end else begin
                  tgt_in   = last;
                  state_in = S_LAST;
               end
            end
         end
         S_LAST: begin
            if (hit) begin
               if (x_ff >= head.pos) begin
                  lo_in    = last;
                  state_in = S_MSTART;
               end else begin
                  lo_in   = '0;
                  hi_in   = last;
                  mid_sum = {1'b0, last};
                  if (last > AW'(1)) begin
                     tgt_in   = mid_sum[AW:1];
                     state_in = S_SEARCH;
                  end else begin
                     tgt_in   = '0;
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (hit) begin
               if (x_ff > head.pos) begin
                  nlo = tgt_ff;
               end else begin
                  nhi = tgt_ff;
               end
               lo_in   = nlo;
               hi_in   = nhi;
               mid_sum = {1'b0, nlo} + {1'b0, nhi};
               if ((nhi - nlo) > AW'(1)) begin
                  tgt_in = mid_sum[AW:1];
               end else begin
                  tgt_in   = nlo;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (hit) begin
               state_in = S_MSTART;
            end
         end
         S_MSTART: begin
            mul_start = 1'b1;
            state_in  = S_MWAIT;
         end
         S_MWAIT: begin
            if (mul_stat.done) begin
               unique case (step_ff)
                  STEP_T: begin
                     acc_in   = spl_pkg::MA_W'(tmp20 >>> 20) + spl_pkg::MA_W'(cur_ff.crv);
                     step_in  = STEP_U;
                     state_in = S_MSTART;
                  end
                  STEP_U: begin
                     acc_in   = spl_pkg::MA_W'(tmp24 >>> 24) + spl_pkg::MA_W'(cur_ff.slp);
                     step_in  = STEP_V;
                     state_in = S_MSTART;
                  end
                  default: begin
                     res_sat_in = v_ovf;
                     if (!v_ovf) begin
                        res_val_in = v_sum[spl_pkg::OUT_W-1:0];
                     end else if (v_sum[spl_pkg::V_W-1]) begin
                        res_val_in = {1'b1, {(spl_pkg::OUT_W - 1){1'b0}}};
                     end else begin
                        res_val_in = {1'b0, {(spl_pkg::OUT_W - 1){1'b1}}};
                     end
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         csr_ff        <= spl_pkg::CSR_W'(2);
         ptr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff     <= tgt_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      res_val_ff <= res_val_in;
      res_sat_ff <= res_sat_in;
      if (req_accept) begin
         x_ff            <= req_tdata[37:6];
         new_knot_ff.pos <= req_tdata[37:6];
         new_knot_ff.val <= req_tdata[85:38];
         new_knot_ff.slp <= req_tdata[133:86];
         new_knot_ff.crv <= req_tdata[197:134];
         new_knot_ff.cub <= req_tdata[261:198];
      end
      if (capture) begin
         cur_ff <= head;
         dx_ff  <= spl_pkg::DX_W'(x_ff) - spl_pkg::DX_W'(head.pos);
      end
      if (rsp_load) begin
         rsp_val_ff <= res_val_ff;
         rsp_seg_ff <= spl_pkg::SEG_W'(lo_ff);
         rsp_sat_ff <= res_sat_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(spl_pkg::RSP_DATA_W - spl_pkg::OUT_W - spl_pkg::SEG_W){1'b0}},
                        rsp_seg_ff, rsp_val_ff};
   assign rsp_tuser  = rsp_sat_ff;

   // ---------------- checks ----------------
   a_mul_idle_start: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiplier restarted while busy");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff < hi_ff) && (tgt_ff > lo_ff) && (tgt_ff < hi_ff))
      else $error("search bounds out of order");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (state_ff == S_IDLE))
      else $error("load did not finish after write");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside done state");

endmodule

[rtl/spl_cell.sv]
// ----------------------------------------------------------------------------
// spl_cell: one knot slot of the rotating knot ring
// Passes its knot to the neighbor each cycle; the slot fed from the head
// takes a new knot on a load.
// ----------------------------------------------------------------------------
module spl_cell (
   input  logic              clock,
   input  spl_pkg::knot_type shift_in,
   input  logic              load_en,
   input  spl_pkg::knot_type load_knot,
   output spl_pkg::knot_type knot_out
);

   spl_pkg::knot_type knot_ff;
   spl_pkg::knot_type knot_in;

   always_comb begin
      knot_in = load_en ? load_knot : shift_in;
   end

   always_ff @(posedge clock) begin
      knot_ff <= knot_in;
   end

   assign knot_out = knot_ff;

endmodule

[rtl/spl_mul.sv]
// ----------------------------------------------------------------------------
// spl_mul: serial signed multiplier
// Radix-2 shift-add, one multiplier bit per cycle, sign bit subtracted.
// ----------------------------------------------------------------------------
module spl_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [spl_pkg::MA_W-1:0]       mult_a,
   input  logic signed [spl_pkg::MB_W-1:0]       mult_b,
   output spl_pkg::mul_stat_type                 stat,
   output logic signed [spl_pkg::PROD_W-1:0]     product
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [spl_pkg::MCNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [spl_pkg::MA_W-1:0] a_ff;
   logic signed [spl_pkg::MA_W:0]   hi_ff;
   logic [spl_pkg::MB_W-1:0]        lo_ff;
   logic signed [spl_pkg::MA_W:0]   ext_a;
   logic signed [spl_pkg::MA_W:0]   addend;
   logic signed [spl_pkg::MA_W:0]   sum;
   logic                            last_bit;

   always_comb begin
      last_bit = (cnt_ff == spl_pkg::MCNT_W'(spl_pkg::MB_W - 1));
      ext_a    = {a_ff[spl_pkg::MA_W-1], a_ff};
      if (lo_ff[0]) begin
         addend = last_bit ? -ext_a : ext_a;
      end else begin
         addend = '0;
      end
      sum = hi_ff + addend;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= mult_a;
         hi_ff <= '0;
         lo_ff <= mult_b;
      end else if (busy_ff) begin
         hi_ff <= {sum[spl_pkg::MA_W], sum[spl_pkg::MA_W:1]};
         lo_ff <= {sum[0], lo_ff[spl_pkg::MB_W-1:1]};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = {hi_ff, lo_ff};

endmodule
